[sv/dgat_pkg.sv]
package dgat_pkg;

  // Occupancy grid bounds
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);

  // Config register file
  localparam int DIM_W  = 7;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Request codes
  localparam logic REQ_SET   = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  // Atlas position per corner mask {TL, TR, BL, BR}
  localparam logic [1:0] ATLAS_COL [16] = '{
    2'd0, 2'd1, 2'd0, 2'd3, 2'd0, 2'd1, 2'd2, 2'd1,
    2'd3, 2'd0, 2'd3, 2'd2, 2'd1, 2'd2, 2'd3, 2'd2
  };
  localparam logic [1:0] ATLAS_ROW [16] = '{
    2'd3, 2'd3, 2'd0, 2'd0, 2'd2, 2'd0, 2'd3, 2'd1,
    2'd3, 2'd1, 2'd2, 2'd0, 2'd2, 2'd2, 2'd1, 2'd1
  };

  // In-range edit handed from front to back
  typedef struct packed {
    logic          req_type;
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic          col_lo_ok;  // column x-1 on the grid
    logic          col_hi_ok;  // column x+1 on the grid
    logic          row_up_ok;  // row y-1 on the grid
    logic          row_dn_ok;  // row y+1 on the grid
  } cmd_t;

  // Handshake between front queue and back sequencer
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

endpackage

[sv/dgat_if.sv]
interface dgat_req_if;
  logic              valid;
  logic              ready;
  logic              req_type;
  logic signed [7:0] cell_x;
  logic signed [7:0] cell_y;

  modport source (output valid, req_type, cell_x, cell_y, input ready);
  modport sink   (input valid, req_type, cell_x, cell_y, output ready);
endinterface

interface dgat_tile_if;
  logic       valid;
  logic       ready;
  logic [6:0] tile_x;
  logic [6:0] tile_y;
  logic [1:0] atlas_col;
  logic [1:0] atlas_row;
  logic       is_blank;
  logic       last;

  modport source (output valid, tile_x, tile_y, atlas_col, atlas_row, is_blank, last,
                  input ready);
  modport sink   (input valid, tile_x, tile_y, atlas_col, atlas_row, is_blank, last,
                  output ready);
endinterface

[sv/dgat_front.sv]
module dgat_front (
  input  logic                         clk,
  input  logic                         rst,
  dgat_req_if.sink                     req,
  input  logic [dgat_pkg::DIM_W-1:0]   grid_width,
  input  logic [dgat_pkg::DIM_W-1:0]   grid_height,
  output dgat_pkg::cmd_head_t          head,
  input  logic                         pop
);

  localparam int QDEPTH = 2;
  localparam int PW = $clog2(QDEPTH);

  logic [dgat_pkg::DIM_W-1:0] eff_w;
  logic [dgat_pkg::DIM_W-1:0] eff_h;
  logic                       in_range;
  logic                       push;
  dgat_pkg::cmd_t             cmd_in;

  dgat_pkg::cmd_t             q [QDEPTH];
  logic [PW-1:0]              wr_ptr;
  logic [PW-1:0]              rd_ptr;
  logic [PW:0]                count;

  // clamp size registers to the grid bounds
  assign eff_w = (grid_width > dgat_pkg::DIM_W'(dgat_pkg::MAX_WIDTH)) ?
                 dgat_pkg::DIM_W'(dgat_pkg::MAX_WIDTH) : grid_width;
  assign eff_h = (grid_height > dgat_pkg::DIM_W'(dgat_pkg::MAX_HEIGHT)) ?
                 dgat_pkg::DIM_W'(dgat_pkg::MAX_HEIGHT) : grid_height;

  assign in_range = !req.cell_x[7] && !req.cell_y[7] &&
                    (req.cell_x[6:0] < eff_w) && (req.cell_y[6:0] < eff_h);

  always_comb begin
    cmd_in.req_type  = req.req_type;
    cmd_in.x         = req.cell_x[dgat_pkg::XW-1:0];
    cmd_in.y         = req.cell_y[dgat_pkg::YW-1:0];
    cmd_in.col_lo_ok = (req.cell_x[6:0] != 7'd0);
    cmd_in.row_up_ok = (req.cell_y[6:0] != 7'd0);
    cmd_in.col_hi_ok = ((req.cell_x[6:0] + 7'd1) < eff_w);
    cmd_in.row_dn_ok = ((req.cell_y[6:0] + 7'd1) < eff_h);
  end

  // out-of-range beats are taken and dropped here
  assign req.ready = (count != (PW+1)'(QDEPTH));
  assign push      = req.valid && req.ready && in_range;

  assign head.valid = (count != '0);
  assign head.cmd   = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (PW+1)'(1);
        2'b01:   count <= count - (PW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[sv/dgat_back.sv]
module dgat_back (
  input  logic                clk,
  input  logic                rst,
  input  dgat_pkg::cmd_head_t head,
  output logic                pop,
  dgat_tile_if.source         tile
);

  localparam int XW = dgat_pkg::XW;
  localparam int YW = dgat_pkg::YW;
  localparam int ROWS = dgat_pkg::MAX_HEIGHT;
  localparam int COLS = dgat_pkg::MAX_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_UP,
    S_RD_MID,
    S_RD_DN,
    S_CHECK,
    S_EMIT
  } state_t;

  state_t           state;
  dgat_pkg::cmd_t   cur;
  logic [1:0]       k;
  logic [2:0]       nb_up;
  logic [2:0]       nb_dn;
  logic [COLS-1:0]  mid_row;

  // occupancy memory, one row per entry, row valid bits cleared at reset
  logic [COLS-1:0]  occ_mem [ROWS];
  logic             row_vld [ROWS];
  logic [COLS-1:0]  rd_row;
  logic             rd_row_vld;
  logic             mem_re;
  logic [YW-1:0]    rd_addr;
  logic             mem_we;
  logic [COLS-1:0]  wr_row;

  logic [COLS-1:0]  row_data;
  logic [XW-1:0]    xm1;
  logic [XW-1:0]    xp1;
  logic [2:0]       row3;
  logic             want;
  logic             cur_bit;
  logic [2:0]       mid3;
  logic [2:0]       top3;
  logic [2:0]       bot3;
  logic [1:0]       dx;
  logic [3:0]       mask;
  logic             out_load;

  assign row_data = rd_row_vld ? rd_row : '0;
  assign xm1      = cur.x - XW'(1);
  assign xp1      = cur.x + XW'(1);
  // three cells around column x; bit 0 is left, bit 2 is right
  assign row3     = {row_data[xp1] & cur.col_hi_ok, row_data[cur.x],
                     row_data[xm1] & cur.col_lo_ok};
  assign want     = (cur.req_type == dgat_pkg::REQ_SET);
  assign cur_bit  = mid_row[cur.x];
  assign mid3     = {mid_row[xp1] & cur.col_hi_ok, want, mid_row[xm1] & cur.col_lo_ok};

  always_comb begin
    mem_re  = 1'b0;
    rd_addr = cur.y;
    unique case (state)
      S_RD_UP: begin
        mem_re  = 1'b1;
        rd_addr = cur.y - YW'(1);
      end
      S_RD_MID: begin
        mem_re  = 1'b1;
        rd_addr = cur.y;
      end
      S_RD_DN: begin
        mem_re  = 1'b1;
        rd_addr = cur.y + YW'(1);
      end
      default: begin
        mem_re  = 1'b0;
        rd_addr = cur.y;
      end
    endcase
  end

  always_comb begin
    wr_row        = mid_row;
    wr_row[cur.x] = want;
  end

  assign mem_we = (state == S_CHECK) && (cur_bit != want);
  assign pop    = (state == S_IDLE) && head.valid;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      occ_mem[cur.y] <= wr_row;
    end
    if (mem_re) begin
      rd_row <= occ_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ROWS; i++) begin
        row_vld[i] <= 1'b0;
      end
      rd_row_vld <= 1'b0;
    end else begin
      if (mem_we) begin
        row_vld[cur.y] <= 1'b1;
      end
      if (mem_re) begin
        rd_row_vld <= row_vld[rd_addr];
      end
    end
  end

  // corner mask of display tile k: dx = k[0], dy = k[1]
  assign top3 = k[1] ? mid3 : nb_up;
  assign bot3 = k[1] ? nb_dn : mid3;
  assign dx   = {1'b0, k[0]};
  assign mask = {top3[dx], top3[dx + 2'd1], bot3[dx], bot3[dx + 2'd1]};

  assign out_load = (state == S_EMIT) && (!tile.valid || tile.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tile.valid <= 1'b0;
    end else begin
      if (out_load) begin
        tile.valid <= 1'b1;
      end else if (tile.ready) begin
        tile.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (head.valid) begin
            cur   <= head.cmd;
            state <= S_RD_UP;
          end
        end
        S_RD_UP: begin
          state <= S_RD_MID;
        end
        S_RD_MID: begin
          nb_up <= row3 & {3{cur.row_up_ok}};
          state <= S_RD_DN;
        end
        S_RD_DN: begin
          mid_row <= row_data;
          state   <= S_CHECK;
        end
        S_CHECK: begin
          nb_dn <= row3 & {3{cur.row_dn_ok}};
          k     <= 2'd0;
          state <= (cur_bit == want) ? S_IDLE : S_EMIT;
        end
        S_EMIT: begin
          if (out_load) begin
            tile.tile_x    <= {1'b0, cur.x} + 7'(k[0]);
            tile.tile_y    <= {1'b0, cur.y} + 7'(k[1]);
            tile.atlas_col <= dgat_pkg::ATLAS_COL[mask];
            tile.atlas_row <= dgat_pkg::ATLAS_ROW[mask];
            tile.is_blank  <= (mask == 4'd0);
            tile.last      <= (k == 2'd3);
            k              <= k + 2'd1;
            if (k == 2'd3) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/dual_grid_autotile_update_core.sv]
// Dual-grid autotile update core.
// req channel: one beat per edit (req_type 0 sets, 1 clears a world cell).
// tile channel: four beats per edit that changes a cell, one per display
//   tile touching it, in order (x,y), (x+1,y), (x,y+1), (x+1,y+1); last
//   marks the fourth. Out-of-range edits and edits that do not change the
//   cell produce no beats.
// APB port: grid_width at 0x0, grid_height at 0x4 (7 bits each, reset 64).
//   Write only while the core is idle.
// The first tile beat is registered after the queue and the back end's
//   read-up, read-mid, read-down and check states. A changing edit holds
//   the back end for three row reads on the single memory read port, a
//   check/write step and four emit beats that stall on tile.ready; a
//   no-change edit ends at the check; out-of-range ones drop at the front.
// A two-entry queue sits between the front classifier and the back end, so
//   req is taken while tile beats wait on a stalled receiver, until full.
// Reset: occupancy reads as empty at once (per-row valid bits), sizes 64.
module dual_grid_autotile_update_core (
  input  logic                          clk,
  input  logic                          rst,
  dgat_req_if.sink                      req,
  dgat_tile_if.source                   tile,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dgat_pkg::ADDR_W-1:0]   paddr,
  input  logic [dgat_pkg::DATA_W-1:0]   pwdata,
  output logic [dgat_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  logic [dgat_pkg::DIM_W-1:0] grid_width;
  logic [dgat_pkg::DIM_W-1:0] grid_height;
  logic                       cfg_wr;
  dgat_pkg::cmd_head_t        head;
  logic                       pop;

  // config registers, decoded on the word address bit
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= dgat_pkg::DIM_W'(dgat_pkg::MAX_WIDTH);
      grid_height <= dgat_pkg::DIM_W'(dgat_pkg::MAX_HEIGHT);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        dgat_pkg::REG_WIDTH:  grid_width  <= pwdata[dgat_pkg::DIM_W-1:0];
        dgat_pkg::REG_HEIGHT: grid_height <= pwdata[dgat_pkg::DIM_W-1:0];
        default:              grid_width  <= grid_width;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      dgat_pkg::REG_WIDTH:
        prdata = {{(dgat_pkg::DATA_W-dgat_pkg::DIM_W){1'b0}}, grid_width};
      dgat_pkg::REG_HEIGHT:
        prdata = {{(dgat_pkg::DATA_W-dgat_pkg::DIM_W){1'b0}}, grid_height};
      default:
        prdata = '0;
    endcase
  end

  // front: range check against the clamped size, queue of valid edits
  dgat_front u_front (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .grid_width  (grid_width),
    .grid_height (grid_height),
    .head        (head),
    .pop         (pop)
  );

  // back: neighborhood read, change check, write-back, tile emit
  dgat_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .tile (tile)
  );

endmodule
